// ----- rtl/sfd_pkg.sv -----
`default_nettype none
package sfd_pkg;

   localparam int STORE_DEPTH_DEF = 16384;
   localparam int SAMPLE_BITS_DEF = 16;

   // output queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;

   // register indexes
   localparam logic [2:0] CSR_DELAY_MODE    = 3'd0;
   localparam logic [2:0] CSR_DELAY_TIME    = 3'd1;
   localparam logic [2:0] CSR_WET_MIX       = 3'd2;
   localparam logic [2:0] CSR_FEEDBACK_GAIN = 3'd3;
   localparam logic [2:0] CSR_SEND_LEVEL    = 3'd4;

   // delay modes
   localparam logic [2:0] MODE_BYPASS  = 3'd0;
   localparam logic [2:0] MODE_DIRECT  = 3'd1;
   localparam logic [2:0] MODE_QUARTER = 3'd2;
   localparam logic [2:0] MODE_TENTH   = 3'd3;
   localparam logic [2:0] MODE_SEVEN   = 3'd4;
   localparam logic [2:0] MODE_FIFTH   = 3'd5;

   // time constants, unsigned Q0.16
   localparam logic [15:0] QUARTER_Q16    = 16'd16384;
   localparam logic [15:0] HALF_Q16       = 16'd32768;
   localparam logic [15:0] THREE_Q_Q16    = 16'd49152;
   localparam logic [15:0] ALMOST_ONE_Q16 = 16'd65535;
   localparam logic [15:0] TENTH_Q16      = 16'd6554;
   localparam logic [15:0] SEVEN_C_Q16    = 16'd4588;
   localparam logic [15:0] FIFTH_Q16      = 16'd13107;

   localparam int CSR_SETTLE = 2;

endpackage
`default_nettype wire

// ----- rtl/stereo_feedback_delay.sv -----
`default_nettype none
// Path from the edge that accepts a req word to the rsp word offered by the output queue:
//   read at that edge, then multiply, then sum/write into the store and the queue.
// Throughput: one word per cycle while req_stall is low; a word that hits the store entry
//   of the word just before it (short delay times) is held until that write-back.
// After each csr write, req_stall stays high while the delay limit is recomputed.
// Reset: synchronous; control registers clear, then both stores are zeroed one entry
//   per cycle, entries 0 to STORE_DEPTH-1, with req_stall high.
module stereo_feedback_delay
   import sfd_pkg::*;
#(
   parameter int STORE_DEPTH = STORE_DEPTH_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  signed [SAMPLE_BITS-1:0] req_sample_left,
   input  wire  signed [SAMPLE_BITS-1:0] req_sample_right,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_left,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_right,
   input  wire                          csr_wr_en,
   input  wire         [2:0]            csr_index,
   input  wire         [15:0]           csr_wdata
);

   localparam int SB    = SAMPLE_BITS;
   localparam int PW    = $clog2(STORE_DEPTH);
   localparam int LW    = PW + 17;
   localparam int PRODW = SB + 17;
   localparam int SUMW  = SB + 18;
   localparam logic [PW-1:0] LAST_ADDR = PW'(STORE_DEPTH - 1);
   localparam logic signed [SUMW-1:0] HALF_LSB = SUMW'(16384);

   typedef logic signed [SB-1:0]    sample_type;
   typedef logic signed [PRODW-1:0] prod_type;
   typedef logic signed [SUMW-1:0]  sum_type;

   function automatic sample_type sat(input sum_type v);
      sample_type r;
      if (v[SUMW-1:SB-1] == {(SUMW-SB+1){1'b0}} || v[SUMW-1:SB-1] == {(SUMW-SB+1){1'b1}}) begin
         r = v[SB-1:0];
      end else if (v[SUMW-1]) begin
         r = {1'b1, {(SB-1){1'b0}}};
      end else begin
         r = {1'b0, {(SB-1){1'b1}}};
      end
      return r;
   endfunction

   // configuration
   logic [2:0]  mode_ff;
   logic [15:0] time_ff, wet_ff, fb_ff, send_ff;
   logic [15:0] eff_in, eff_ff;
   logic [LW-1:0] limit_ff;
   logic [1:0]  settle_ff;
   logic [15:0] coef;
   logic [31:0] scaled;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_BYPASS;
         time_ff   <= '0;
         wet_ff    <= '0;
         fb_ff     <= '0;
         send_ff   <= '0;
         settle_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            settle_ff <= 2'(CSR_SETTLE);
            unique case (csr_index)
               CSR_DELAY_MODE:    mode_ff <= csr_wdata[2:0];
               CSR_DELAY_TIME:    time_ff <= csr_wdata;
               CSR_WET_MIX:       wet_ff  <= csr_wdata;
               CSR_FEEDBACK_GAIN: fb_ff   <= csr_wdata;
               CSR_SEND_LEVEL:    send_ff <= csr_wdata;
               default: ;
            endcase
         end else if (settle_ff != 2'd0) begin
            settle_ff <= settle_ff - 2'd1;
         end
      end
   end

   always_comb begin
      unique case (mode_ff)
         MODE_TENTH: coef = TENTH_Q16;
         MODE_SEVEN: coef = SEVEN_C_Q16;
         default:    coef = FIFTH_Q16;
      endcase
      scaled = 32'(time_ff) * 32'(coef);
      unique case (mode_ff)
         MODE_QUARTER: begin
            priority if (time_ff == 16'd0) eff_in = 16'd0;
            else if (time_ff <= QUARTER_Q16) eff_in = QUARTER_Q16;
            else if (time_ff <= HALF_Q16)    eff_in = HALF_Q16;
            else if (time_ff <= THREE_Q_Q16) eff_in = THREE_Q_Q16;
            else                             eff_in = ALMOST_ONE_Q16;
         end
         MODE_TENTH, MODE_SEVEN, MODE_FIFTH: eff_in = scaled[31:16];
         MODE_DIRECT: eff_in = time_ff;
         default:     eff_in = time_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_ff   <= '0;
         limit_ff <= '0;
      end else begin
         eff_ff   <= eff_in;
         limit_ff <= LW'(eff_ff) * LW'(STORE_DEPTH);
      end
   end

   // clearing pass
   logic          clr_active_ff;
   logic [PW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         clr_addr_ff <= clr_addr_ff + PW'(1);
         if (clr_addr_ff == LAST_ADDR) clr_active_ff <= 1'b0;
      end
   end

   // pipeline control
   logic                 s1_v_ff, s2_v_ff;
   logic                 s1_byp_ff, s2_byp_ff;
   logic [PW-1:0]        s1_addr_ff, s2_addr_ff;
   logic [PW-1:0]        pos_ff, pos_in;
   logic [PW:0]          pos_inc;
   logic                 wrap;
   logic [FIFO_AW:0]     fifo_cnt_ff;
   logic [FIFO_AW:0]     inflight;
   logic                 hazard, accept, bypass, rd_en;

   assign bypass   = (mode_ff == MODE_BYPASS);
   assign inflight = (FIFO_AW+1)'(s1_v_ff) + (FIFO_AW+1)'(s2_v_ff) + fifo_cnt_ff;
   // hold a word whose entry is still being rewritten by the word ahead
   assign hazard   = s1_v_ff && !s1_byp_ff && (s1_addr_ff == pos_ff);
   assign req_stall = clr_active_ff || (settle_ff != 2'd0) || hazard ||
                      (inflight >= (FIFO_AW+1)'(FIFO_DEPTH));
   assign accept   = req_valid && !req_stall;
   assign rd_en    = accept && !bypass;

   assign pos_inc = {1'b0, pos_ff} + (PW+1)'(1);
   assign wrap    = ({pos_inc, 16'd0} >= limit_ff);
   assign pos_in  = wrap ? '0 : pos_inc[PW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         if (rd_en) pos_ff <= pos_in;
         s1_v_ff <= accept;
         s2_v_ff <= s1_v_ff;
      end
   end

   // store memories
   sample_type mem_l [STORE_DEPTH];
   sample_type mem_r [STORE_DEPTH];
   sample_type q_l_ff, q_r_ff;
   logic          wr_en;
   logic [PW-1:0] wr_addr;
   sample_type    wr_l, wr_r, new_l, new_r;
   logic          fwd_hit_ff;
   sample_type    fwd_l_ff, fwd_r_ff;

   assign wr_en   = clr_active_ff || (s2_v_ff && !s2_byp_ff);
   assign wr_addr = clr_active_ff ? clr_addr_ff : s2_addr_ff;
   assign wr_l    = clr_active_ff ? '0 : new_l;
   assign wr_r    = clr_active_ff ? '0 : new_r;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_l[wr_addr] <= wr_l;
         mem_r[wr_addr] <= wr_r;
      end
      if (rd_en) begin
         q_l_ff <= mem_l[pos_ff];
         q_r_ff <= mem_r[pos_ff];
      end
   end

   // a read that meets the same-edge write takes the new word
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else begin
         fwd_hit_ff <= rd_en && wr_en && (wr_addr == pos_ff);
      end
      fwd_l_ff <= wr_l;
      fwd_r_ff <= wr_r;
   end

   // stage 1: multiply
   sample_type s1_xl_ff, s1_xr_ff, s2_xl_ff, s2_xr_ff;
   sample_type st_l, st_r;
   prod_type   wetp_l_ff, wetp_r_ff, fbp_l_ff, fbp_r_ff, sndp_l_ff, sndp_r_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byp_ff  <= bypass;
         s1_addr_ff <= pos_ff;
         s1_xl_ff   <= req_sample_left;
         s1_xr_ff   <= req_sample_right;
      end
   end

   assign st_l = fwd_hit_ff ? fwd_l_ff : q_l_ff;
   assign st_r = fwd_hit_ff ? fwd_r_ff : q_r_ff;

   always_ff @(posedge clock) begin
      s2_byp_ff  <= s1_byp_ff;
      s2_addr_ff <= s1_addr_ff;
      s2_xl_ff   <= s1_xl_ff;
      s2_xr_ff   <= s1_xr_ff;
      wetp_l_ff  <= PRODW'(st_l) * $signed({1'b0, wet_ff});
      wetp_r_ff  <= PRODW'(st_r) * $signed({1'b0, wet_ff});
      fbp_l_ff   <= PRODW'(st_l) * $signed({1'b0, fb_ff});
      fbp_r_ff   <= PRODW'(st_r) * $signed({1'b0, fb_ff});
      sndp_l_ff  <= PRODW'(s1_xl_ff) * $signed({1'b0, send_ff});
      sndp_r_ff  <= PRODW'(s1_xr_ff) * $signed({1'b0, send_ff});
   end

   // stage 2: round, saturate, write back
   sum_type    wet_l, wet_r, fbs_l, fbs_r;
   sample_type y_l, y_r;

   always_comb begin
      wet_l = (SUMW'(wetp_l_ff) + HALF_LSB) >>> 15;
      wet_r = (SUMW'(wetp_r_ff) + HALF_LSB) >>> 15;
      fbs_l = (SUMW'(fbp_l_ff) + SUMW'(sndp_l_ff) + HALF_LSB) >>> 15;
      fbs_r = (SUMW'(fbp_r_ff) + SUMW'(sndp_r_ff) + HALF_LSB) >>> 15;
      new_l = sat(fbs_l);
      new_r = sat(fbs_r);
      y_l   = s2_byp_ff ? s2_xl_ff : sat(SUMW'(s2_xl_ff) + wet_l);
      y_r   = s2_byp_ff ? s2_xr_ff : sat(SUMW'(s2_xr_ff) + wet_r);
   end

   // output queue
   sample_type       fifo_l [FIFO_DEPTH];
   sample_type       fifo_r [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wptr_ff, rptr_ff;
   logic             pop;

   assign rsp_valid     = (fifo_cnt_ff != '0);
   assign pop           = rsp_valid && !rsp_stall;
   assign rsp_out_left  = fifo_l[rptr_ff];
   assign rsp_out_right = fifo_r[rptr_ff];

   always_ff @(posedge clock) begin
      if (s2_v_ff) begin
         fifo_l[wptr_ff] <= y_l;
         fifo_r[wptr_ff] <= y_r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff     <= '0;
         rptr_ff     <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (s2_v_ff) wptr_ff <= wptr_ff + FIFO_AW'(1);
         if (pop)     rptr_ff <= rptr_ff + FIFO_AW'(1);
         fifo_cnt_ff <= fifo_cnt_ff + (FIFO_AW+1)'(s2_v_ff) - (FIFO_AW+1)'(pop);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      inflight <= (FIFO_AW+1)'(FIFO_DEPTH))
      else $error("output queue overrun");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !accept && !s1_v_ff && !s2_v_ff)
      else $error("word in flight during clearing pass");

   a_no_raw_overlap: assert property (@(posedge clock) disable iff (reset)
      rd_en && s1_v_ff && !s1_byp_ff |-> s1_addr_ff != pos_ff)
      else $error("read overlaps pending write-back");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> pos_ff <= LAST_ADDR)
      else $error("position out of range");

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
module testbench;
   import sfd_pkg::*;

   localparam int DEPTH      = 16384;
   localparam int MAX_CYCLES = 400000;
   localparam int LONG_HOLD  = 300;
   localparam int PRINT_CAP  = 40;
   localparam int RANDOM_WORDS = 1100;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] right;
   } stereo_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_sample_left  = '0;
   logic signed [15:0] req_sample_right = '0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic signed [15:0] rsp_out_left;
   logic signed [15:0] rsp_out_right;
   logic               csr_wr_en        = 1'b0;
   logic [2:0]         csr_index        = CSR_DELAY_MODE;
   logic [15:0]        csr_wdata        = '0;

   always #4 clock = ~clock;

   stereo_feedback_delay u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_left  (req_sample_left),
      .req_sample_right (req_sample_right),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_left     (rsp_out_left),
      .rsp_out_right    (rsp_out_right),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // mirror of the block's settings and echo memory
   logic [2:0]         cfg_mode     = MODE_BYPASS;
   logic [15:0]        cfg_time     = '0;
   logic [15:0]        cfg_wet      = '0;
   logic [15:0]        cfg_feedback = '0;
   logic [15:0]        cfg_send     = '0;
   logic signed [15:0] echo_left  [DEPTH];
   logic signed [15:0] echo_right [DEPTH];
   int                 echo_pos = 0;

   stereo_type frames_to_send[$];
   stereo_type outputs_due[$];

   int sender_idle_pct = 0;
   int stall_pct       = 0;
   bit hold_receiver   = 1'b0;
   int mismatches      = 0;
   int cycle_count     = 0;

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // Q1.15 product back to sample scale, round half up
   function automatic longint scale_q15(longint v);
      return (v + 16384) >>> 15;
   endfunction

   function automatic longint delay_span();
      longint t;
      t = longint'(cfg_time);
      case (cfg_mode)
         MODE_QUARTER: begin
            if (t == 0) return 0;
            if (t <= longint'(QUARTER_Q16)) return longint'(QUARTER_Q16);
            if (t <= longint'(HALF_Q16)) return longint'(HALF_Q16);
            if (t <= longint'(THREE_Q_Q16)) return longint'(THREE_Q_Q16);
            return longint'(ALMOST_ONE_Q16);
         end
         MODE_TENTH: return (t * longint'(TENTH_Q16)) >>> 16;
         MODE_SEVEN: return (t * longint'(SEVEN_C_Q16)) >>> 16;
         MODE_FIFTH: return (t * longint'(FIFTH_Q16)) >>> 16;
         default: return t;
      endcase
   endfunction

   task automatic compute_echo(stereo_type dry);
      stereo_type wet_out;
      longint  in_l, in_r, tap_l, tap_r, wet, fb, send;
      if (cfg_mode == MODE_BYPASS) begin
         wet_out = dry;
      end else begin
         in_l  = longint'(dry.left);
         in_r  = longint'(dry.right);
         tap_l = longint'(echo_left[echo_pos]);
         tap_r = longint'(echo_right[echo_pos]);
         wet   = longint'(cfg_wet);
         fb    = longint'(cfg_feedback);
         send  = longint'(cfg_send);
         // output uses the word read before the rewrite
         wet_out.left  = clamp16(in_l + scale_q15(tap_l * wet));
         wet_out.right = clamp16(in_r + scale_q15(tap_r * wet));
         echo_left[echo_pos]  = clamp16(scale_q15(tap_l * fb + in_l * send));
         echo_right[echo_pos] = clamp16(scale_q15(tap_r * fb + in_r * send));
         if ((longint'(echo_pos) + 1) * 65536 >= longint'(DEPTH) * delay_span())
            echo_pos = 0;
         else
            echo_pos = echo_pos + 1;
      end
      outputs_due.push_back(wet_out);
   endtask

   task automatic report_mismatch(string what);
      if (mismatches < PRINT_CAP) $display("ERROR at %0t: %s", $time, what);
      mismatches++;
   endtask

   // request side: hold a stalled word, advance on acceptance
   always @(posedge clock) begin : drive_req
      stereo_type next_frame;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            compute_echo(stereo_type'{req_sample_left, req_sample_right});
         if (!req_valid || !req_stall) begin
            if (frames_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_frame = frames_to_send.pop_front();
               req_valid        <= 1'b1;
               req_sample_left  <= next_frame.left;
               req_sample_right <= next_frame.right;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      stereo_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (outputs_due.size() == 0) begin
               report_mismatch($sformatf("unexpected word L=%0d R=%0d",
                                         rsp_out_left, rsp_out_right));
            end else begin
               want = outputs_due.pop_front();
               if (rsp_out_left !== want.left)
                  report_mismatch($sformatf("out_left %0d, want %0d", rsp_out_left, want.left));
               if (rsp_out_right !== want.right)
                  report_mismatch($sformatf("out_right %0d, want %0d",
                                            rsp_out_right, want.right));
            end
         end
         rsp_stall <= hold_receiver || ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= MAX_CYCLES) begin
         $display("stereo_feedback_delay: mismatch");
         $finish;
      end
   end

   function automatic logic signed [15:0] pick_sample();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 50) return 16'($urandom);
      if (r < 80) return 16'($urandom_range(4000) - 2000);
      case ($urandom_range(3))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sh0000;
         default: return -16'sd1;
      endcase
   endfunction

   function automatic logic [15:0] pick_time();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 40) return 16'($urandom_range(400));
      if (r < 60) return 16'($urandom_range(4000));
      if (r < 75) return 16'($urandom);
      if (r < 85) return 16'd0;
      return 16'hffff;
   endfunction

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(5))
         0: return 16'd0;
         1: return 16'd32768;
         2: return 16'hffff;
         3: return 16'($urandom);
         default: return 16'($urandom_range(32768));
      endcase
   endfunction

   // wait until nothing is queued, in flight or owed
   task automatic drain();
      while (frames_to_send.size() != 0 || req_valid || outputs_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic load_settings(logic [2:0] mode, logic [15:0] dtime, logic [15:0] wet,
                                logic [15:0] fb, logic [15:0] send);
      logic [2:0]  reg_ids  [5];
      logic [15:0] reg_vals [5];
      reg_ids  = '{CSR_DELAY_MODE, CSR_DELAY_TIME, CSR_WET_MIX, CSR_FEEDBACK_GAIN,
                   CSR_SEND_LEVEL};
      reg_vals = '{{13'd0, mode}, dtime, wet, fb, send};
      for (int i = 0; i < 5; i++) begin
         @(posedge clock);
         csr_wr_en <= 1'b1;
         csr_index <= reg_ids[i];
         csr_wdata <= reg_vals[i];
      end
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      cfg_mode     = mode;
      cfg_time     = dtime;
      cfg_wet      = wet;
      cfg_feedback = fb;
      cfg_send     = send;
      @(negedge clock);
   endtask

   task automatic queue_frame(logic signed [15:0] l, logic signed [15:0] r);
      frames_to_send.push_back(stereo_type'{l, r});
   endtask

   initial begin : stimulus
      int sent;
      int phase;
      int n;
      foreach (echo_left[i]) begin
         echo_left[i]  = '0;
         echo_right[i] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // the block clears its memory after reset with req_stall high
      repeat (2) @(negedge clock);
      while (req_stall) @(negedge clock);

      // bypass passes samples through untouched
      load_settings(MODE_BYPASS, 16'd8, 16'hffff, 16'hffff, 16'hffff);
      queue_frame(16'sh7fff, 16'sh8000);
      queue_frame(16'sh8000, 16'sh7fff);
      queue_frame(-16'sd1, 16'sh0000);
      drain();

      // two-word loop with gains above unity: saturation on both paths
      load_settings(MODE_DIRECT, 16'd8, 16'hffff, 16'hffff, 16'hffff);
      queue_frame(16'sh7fff, 16'sh7fff);
      queue_frame(16'sh8000, 16'sh8000);
      queue_frame(16'sh7fff, 16'sh8000);
      queue_frame(16'sh8000, 16'sh7fff);
      queue_frame(16'sd1, -16'sd1);
      queue_frame(16'sh0000, 16'sh0000);
      queue_frame(-16'sd1, 16'sd1);
      queue_frame(16'sh7fff, 16'sh8000);
      drain();

      // zero time: position pinned at word 0
      load_settings(MODE_DIRECT, 16'd0, 16'd32768, 16'd32768, 16'd32768);
      queue_frame(16'sd1000, -16'sd1000);
      queue_frame(-16'sd1, -16'sd1);
      queue_frame(16'sh7fff, 16'sh8000);
      drain();

      // shorten the time while the position lies past the new limit
      load_settings(MODE_DIRECT, 16'd200, 16'd16384, 16'd24000, 16'd32768);
      repeat (5) queue_frame(pick_sample(), pick_sample());
      drain();
      load_settings(MODE_DIRECT, 16'd8, 16'd16384, 16'd24000, 16'd32768);
      repeat (4) queue_frame(pick_sample(), pick_sample());

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_WORDS) begin
         drain();
         load_settings(3'(phase % 8), (phase == 9) ? 16'hffff : pick_time(),
                       pick_gain(), pick_gain(), pick_gain());
         case ($urandom_range(3))
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 80; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 80; end
            default: begin sender_idle_pct = 8; stall_pct = 8; end
         endcase
         n = $urandom_range(20, 80);
         if (phase == 3) begin
            // hold off the receiver so the block backs up into its input
            sender_idle_pct = 0;
            n = 80;
            fork
               begin
                  hold_receiver = 1'b1;
                  repeat (LONG_HOLD) @(negedge clock);
                  hold_receiver = 1'b0;
               end
            join_none
         end
         repeat (n) queue_frame(pick_sample(), pick_sample());
         sent += n;
         phase++;
      end
      drain();
      repeat (10) @(negedge clock);
      if (mismatches == 0)
         $display("stereo_feedback_delay: match");
      else
         $display("stereo_feedback_delay: mismatch");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/sfd_pkg.sv
rtl/stereo_feedback_delay.sv
tb/sv/testbench.sv
